[sv/cle_pkg.sv]
// Shared types, action codes and status codes for the circular list engine.
package cle_pkg;

	typedef logic [2:0]         action_t;
	typedef logic [1:0]         status_t;
	typedef logic signed [31:0] value_t;

	localparam action_t ACT_INS_FRONT = 3'd0;
	localparam action_t ACT_INS_BACK  = 3'd1;
	localparam action_t ACT_SEARCH    = 3'd2;
	localparam action_t ACT_REMOVE    = 3'd3;
	localparam action_t ACT_READ_OUT  = 3'd4;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_FULL      = 2'd2;
	localparam status_t ST_EMPTY     = 2'd3;

endpackage

[sv/cle_in_if.sv]
// Command channel: action and value, valid/ready handshake.
interface cle_in_if;
	logic               valid;
	logic               ready;
	cle_pkg::action_t   action;
	cle_pkg::value_t    value;

	modport source (output valid, action, value, input ready);
	modport sink   (input valid, action, value, output ready);
endinterface

[sv/cle_out_if.sv]
// Result channel: status, value and last flag, valid/ready handshake.
interface cle_out_if;
	logic               valid;
	logic               ready;
	cle_pkg::status_t   status;
	cle_pkg::value_t    item_value;
	logic               last;

	modport source (output valid, status, item_value, last, input ready);
	modport sink   (input valid, status, item_value, last, output ready);
endinterface

[sv/circular_list_engine.sv]
// Top level: list sequencer walking the node pool one node per cycle.
// Sequence: insert-front allocates a node (S_ALLOC) and emits; full, empty and unknown actions
//   go straight to S_EMIT; insert-back walks to the tail (S_TAIL), search and remove walk in
//   S_CMP up to the match, and remove then frees the node onto the free chain (S_FREE).
// Read-out streams one value per cycle after a one-cycle lookup, gated by the result side.
// Throughput: one command at a time; the single read port of the pool sets the walk rate.
// Reset: asynchronous, active low; the list comes up empty and the whole pool is free.
module circular_list_engine #(
	parameter int CAPACITY = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	cle_in_if.sink     cmd,
	cle_out_if.source  res
);

	localparam int IdxW = $clog2(CAPACITY);
	localparam int PtrW = $clog2(CAPACITY + 1);
	// Pointer value CAPACITY closes the ring (end of list / no free node).
	localparam logic [PtrW-1:0] EndPtr = PtrW'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_TAIL,
		S_CMP,
		S_FREE,
		S_RD,
		S_EMIT
	} state_t;

	state_t state_q, state_d;

	cle_pkg::action_t action_q, action_d;
	cle_pkg::value_t  value_q, value_d;
	cle_pkg::status_t status_q, status_d;
	logic [PtrW-1:0]  first_q, first_d;
	logic [PtrW-1:0]  free_q, free_d;
	logic [PtrW-1:0]  count_q, count_d;
	logic [PtrW-1:0]  cur_q, cur_d;
	logic [PtrW-1:0]  prev_q, prev_d;
	logic [PtrW-1:0]  node_q, node_d;
	logic [PtrW-1:0]  steps_q, steps_d;

	// Result register
	logic             res_valid_q, res_valid_d;
	cle_pkg::status_t res_status_q, res_status_d;
	cle_pkg::value_t  res_value_q, res_value_d;
	logic             res_last_q, res_last_d;

	// Pool port
	logic             rd_en;
	logic [IdxW-1:0]  raddr;
	logic             wr_val_en;
	logic             wr_link_en;
	logic [IdxW-1:0]  waddr;
	cle_pkg::value_t  wval;
	logic [PtrW-1:0]  wlink;
	cle_pkg::value_t  rd_val;
	logic [PtrW-1:0]  rd_link;

	logic             out_free;
	logic             link_ok;
	logic             fin;

	cle_pool #(.CAPACITY(CAPACITY)) u_pool (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (rd_en),
		.raddr      (raddr),
		.wr_val_en  (wr_val_en),
		.wr_link_en (wr_link_en),
		.waddr      (waddr),
		.wval       (wval),
		.wlink      (wlink),
		.rd_val     (rd_val),
		.rd_link    (rd_link)
	);

	// The result register can take a new transaction when empty or being drained.
	assign out_free = !res_valid_q || res.ready;
	assign link_ok  = rd_link < EndPtr;
	assign fin      = !link_ok || (steps_q == PtrW'(CAPACITY - 1));

	assign cmd.ready      = (state_q == S_IDLE);
	assign res.valid      = res_valid_q;
	assign res.status     = res_status_q;
	assign res.item_value = res_value_q;
	assign res.last       = res_last_q;

	always_comb begin
		state_d      = state_q;
		action_d     = action_q;
		value_d      = value_q;
		status_d     = status_q;
		first_d      = first_q;
		free_d       = free_q;
		count_d      = count_q;
		cur_d        = cur_q;
		prev_d       = prev_q;
		node_d       = node_q;
		steps_d      = steps_q;
		res_valid_d  = res_valid_q && !res.ready;
		res_status_d = res_status_q;
		res_value_d  = res_value_q;
		res_last_d   = res_last_q;
		rd_en        = 1'b0;
		raddr        = cur_q[IdxW-1:0];
		wr_val_en    = 1'b0;
		wr_link_en   = 1'b0;
		waddr        = cur_q[IdxW-1:0];
		wval         = value_q;
		wlink        = EndPtr;

		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					action_d = cmd.action;
					value_d  = cmd.value;
					status_d = cle_pkg::ST_OK;
					steps_d  = '0;
					prev_d   = EndPtr;
					unique case (cmd.action) inside
						cle_pkg::ACT_INS_FRONT, cle_pkg::ACT_INS_BACK: begin
							if (free_q < EndPtr) begin
								rd_en   = 1'b1;
								raddr   = free_q[IdxW-1:0];
								node_d  = free_q;
								state_d = S_ALLOC;
							end else begin
								status_d = cle_pkg::ST_FULL;
								state_d  = S_EMIT;
							end
						end
						cle_pkg::ACT_SEARCH, cle_pkg::ACT_REMOVE: begin
							if (first_q < EndPtr) begin
								rd_en   = 1'b1;
								raddr   = first_q[IdxW-1:0];
								cur_d   = first_q;
								state_d = S_CMP;
							end else begin
								status_d = cle_pkg::ST_NOT_FOUND;
								state_d  = S_EMIT;
							end
						end
						cle_pkg::ACT_READ_OUT: begin
							if (first_q < EndPtr) begin
								rd_en   = 1'b1;
								raddr   = first_q[IdxW-1:0];
								cur_d   = first_q;
								state_d = S_RD;
							end else begin
								status_d = cle_pkg::ST_EMPTY;
								value_d  = '0;
								state_d  = S_EMIT;
							end
						end
						default: begin
							status_d = cle_pkg::ST_NOT_FOUND;
							state_d  = S_EMIT;
						end
					endcase
				end
			end
			S_ALLOC: begin
				// rd_link is the successor of the taken node on the free chain
				free_d     = rd_link;
				wr_val_en  = 1'b1;
				wr_link_en = 1'b1;
				waddr      = node_q[IdxW-1:0];
				if (action_q == cle_pkg::ACT_INS_FRONT) begin
					wlink   = first_q;
					first_d = node_q;
					count_d = count_q + PtrW'(1);
					state_d = S_EMIT;
				end else begin
					wlink = EndPtr;
					if (first_q < EndPtr) begin
						rd_en   = 1'b1;
						raddr   = first_q[IdxW-1:0];
						cur_d   = first_q;
						state_d = S_TAIL;
					end else begin
						first_d = node_q;
						count_d = count_q + PtrW'(1);
						state_d = S_EMIT;
					end
				end
			end
			S_TAIL: begin
				if (link_ok && (steps_q != EndPtr)) begin
					rd_en   = 1'b1;
					raddr   = rd_link[IdxW-1:0];
					cur_d   = rd_link;
					steps_d = steps_q + PtrW'(1);
				end else begin
					wr_link_en = 1'b1;
					wlink      = node_q;
					count_d    = count_q + PtrW'(1);
					state_d    = S_EMIT;
				end
			end
			S_CMP: begin
				if (rd_val == value_q) begin
					if (action_q == cle_pkg::ACT_REMOVE) begin
						if (prev_q < EndPtr) begin
							wr_link_en = 1'b1;
							waddr      = prev_q[IdxW-1:0];
							wlink      = rd_link;
						end else begin
							first_d = rd_link;
						end
						state_d = S_FREE;
					end else begin
						state_d = S_EMIT;
					end
				end else if (link_ok && (steps_q != PtrW'(CAPACITY - 1))) begin
					rd_en   = 1'b1;
					raddr   = rd_link[IdxW-1:0];
					prev_d  = cur_q;
					cur_d   = rd_link;
					steps_d = steps_q + PtrW'(1);
				end else begin
					status_d = cle_pkg::ST_NOT_FOUND;
					state_d  = S_EMIT;
				end
			end
			S_FREE: begin
				// unlinked node goes to the head of the free chain
				wr_link_en = 1'b1;
				wlink      = free_q;
				free_d     = cur_q;
				count_d    = count_q - PtrW'(1);
				state_d    = S_EMIT;
			end
			S_RD: begin
				if (out_free) begin
					res_valid_d  = 1'b1;
					res_status_d = cle_pkg::ST_OK;
					res_value_d  = rd_val;
					res_last_d   = fin;
					if (fin) begin
						state_d = S_IDLE;
					end else begin
						rd_en   = 1'b1;
						raddr   = rd_link[IdxW-1:0];
						cur_d   = rd_link;
						steps_d = steps_q + PtrW'(1);
					end
				end
			end
			S_EMIT: begin
				if (out_free) begin
					res_valid_d  = 1'b1;
					res_status_d = status_q;
					res_value_d  = value_q;
					res_last_d   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			first_q     <= EndPtr;
			free_q      <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			first_q     <= first_d;
			free_q      <= free_d;
			count_q     <= count_d;
			res_valid_q <= res_valid_d;
		end
	end

	// Payload and walk registers
	always_ff @(posedge clk) begin
		action_q     <= action_d;
		value_q      <= value_d;
		status_q     <= status_d;
		cur_q        <= cur_d;
		prev_q       <= prev_d;
		node_q       <= node_d;
		steps_q      <= steps_d;
		res_status_q <= res_status_d;
		res_value_q  <= res_value_d;
		res_last_q   <= res_last_d;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= EndPtr)
		else $error("entry count beyond capacity");

	a_empty_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((first_q == EndPtr) == (count_q == '0)))
		else $error("list head disagrees with entry count");

	a_full_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((free_q == EndPtr) == (count_q == EndPtr)))
		else $error("free chain disagrees with entry count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("new transaction taken while busy");

	a_readout_emits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RD) && out_free) |=> res.valid)
		else $error("read-out step produced no result");

endmodule

[sv/cle_pool.sv]
// Node pool: value and link memories with one registered read port.
module cle_pool #(
	parameter int CAPACITY = 16,
	localparam int IdxW = $clog2(CAPACITY),
	localparam int PtrW = $clog2(CAPACITY + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [IdxW-1:0]     raddr,
	input  logic                wr_val_en,
	input  logic                wr_link_en,
	input  logic [IdxW-1:0]     waddr,
	input  cle_pkg::value_t     wval,
	input  logic [PtrW-1:0]     wlink,
	output cle_pkg::value_t     rd_val,
	output logic [PtrW-1:0]     rd_link
);

	cle_pkg::value_t   val_mem [CAPACITY];
	logic [PtrW-1:0]   link_mem [CAPACITY];
	logic [CAPACITY-1:0] link_ok_q;

	cle_pkg::value_t   rd_val_s1;
	logic [PtrW-1:0]   link_raw_s1;
	logic [IdxW-1:0]   idx_s1;
	logic              link_ok_s1;

	always_ff @(posedge clk) begin
		if (wr_val_en)
			val_mem[waddr] <= wval;
		if (wr_link_en)
			link_mem[waddr] <= wlink;
		if (rd_en) begin
			rd_val_s1   <= val_mem[raddr];
			link_raw_s1 <= link_mem[raddr];
			idx_s1      <= raddr;
		end
	end

	// A link never written reads as its reset value: the next node of the free chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_ok_q  <= '0;
			link_ok_s1 <= 1'b0;
		end else begin
			if (wr_link_en)
				link_ok_q[waddr] <= 1'b1;
			if (rd_en)
				link_ok_s1 <= link_ok_q[raddr];
		end
	end

	assign rd_val  = rd_val_s1;
	assign rd_link = link_ok_s1 ? link_raw_s1 : PtrW'(idx_s1) + PtrW'(1);

endmodule
